// File: src/skdt_pkg.sv
// Shared types and constants for the strongest-k device table.
// No dependencies.
package skdt_pkg;

	typedef enum logic [1:0] {
		MODE_UPSERT = 2'd0,
		MODE_READ   = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Classified command passed from front to back.
	typedef struct packed {
		logic [1:0]  mode;
		logic        ok;
		logic [63:0] identity;
		logic [3:0]  identity_length;
		logic [7:0]  rssi;
		logic [63:0] label;
		logic [3:0]  label_length;
		logic [5:0]  entry_index;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SORT,
		ST_DONE
	} state_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < n) m[b*8 +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

// File: src/skdt_front.sv
// Front end: accepts input beats, validates and masks them, feeds a short queue.
// Depends on skdt_pkg.
module skdt_front import skdt_pkg::*; #(
	parameter int ID_BYTES    = 8,
	parameter int LABEL_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  mode,
	input  logic        is_ble,
	input  logic [63:0] identity,
	input  logic [3:0]  identity_length,
	input  logic [7:0]  rssi,
	input  logic [63:0] label,
	input  logic [3:0]  label_length,
	input  logic [5:0]  entry_index,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);

	localparam logic [3:0] IdMax  = 4'(ID_BYTES);
	localparam logic [3:0] LabMax = 4'(LABEL_BYTES);

	cmd_t       in_cmd;
	logic [3:0] labl;
	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	always_comb begin
		labl = (label_length > LabMax) ? LabMax : label_length;
		in_cmd.mode            = mode;
		in_cmd.ok              = is_ble && identity_length != 4'd0 &&
		                         identity_length <= IdMax;
		in_cmd.identity        = identity & byte_mask(identity_length);
		in_cmd.identity_length = identity_length;
		in_cmd.rssi            = rssi;
		in_cmd.label           = label & byte_mask(labl);
		in_cmd.label_length    = labl;
		in_cmd.entry_index     = entry_index;
	end

	assign ready     = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (valid && ready) fifo_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (valid && ready) wr_ptr_q <= ~wr_ptr_q;
			if (cmd_valid && cmd_ready) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(valid && ready) - 2'(cmd_valid && cmd_ready);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !(cmd_valid && cmd_ready) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !cmd_valid)
		else $error("empty queue presents a command");

endmodule

// File: src/skdt_back.sv
// Back end: table storage, keyed search, insertion sort and result register.
// Depends on skdt_pkg.
module skdt_back import skdt_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        changed,
	output logic        entry_valid,
	output logic [63:0] entry_identity,
	output logic [3:0]  entry_identity_length,
	output logic [7:0]  entry_rssi,
	output logic [63:0] entry_label,
	output logic [3:0]  entry_label_length,
	output logic [6:0]  entry_count,
	output logic [31:0] revision
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [6:0] Cap = 7'(CAPACITY);

	logic [63:0] id_q   [CAPACITY];
	logic [3:0]  idl_q  [CAPACITY];
	logic [7:0]  rs_q   [CAPACITY];
	logic [63:0] lab_q  [CAPACITY];
	logic [3:0]  labl_q [CAPACITY];
	logic [6:0]  held_q;
	logic [31:0] rev_q;

	state_t     state_q, state_d;
	cmd_t       cmd_q;
	logic [6:0] k_q;    // search position
	logic [6:0] i_q;    // sort outer position
	logic [6:0] j_q;    // sort inner position
	logic       busy_out_q;
	logic       chg_q;

	logic       hit, diff, need_swap, in_range;
	logic [IW-1:0] kx, jx, jm1, ix;

	assign kx  = k_q[IW-1:0];
	assign jx  = j_q[IW-1:0];
	assign jm1 = IW'(j_q - 7'd1);
	assign ix  = cmd_q.entry_index[IW-1:0];
	assign hit = idl_q[kx] == cmd_q.identity_length && id_q[kx] == cmd_q.identity;
	assign diff = rs_q[kx] != cmd_q.rssi || labl_q[kx] != cmd_q.label_length ||
	              lab_q[kx] != cmd_q.label;
	// only compare entries below the held count
	assign need_swap = i_q < held_q && j_q != 7'd0 &&
	                   $signed(rs_q[jm1]) < $signed(rs_q[jx]);
	assign in_range = {1'b0, cmd_q.entry_index} < held_q;

	assign out_valid = busy_out_q;
	assign cmd_ready = state_q == ST_IDLE && !busy_out_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd_valid && cmd_ready) state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (cmd_q.mode != MODE_UPSERT || !cmd_q.ok) state_d = ST_DONE;
				else if (k_q < held_q && hit) state_d = diff ? ST_SORT : ST_DONE;
				else if (k_q < held_q) state_d = ST_SEARCH;
				else if (held_q < Cap) state_d = ST_SORT;
				else if ($signed(cmd_q.rssi) > $signed(rs_q[IW'(CAPACITY-1)]))
					state_d = ST_SORT;
				else state_d = ST_DONE;
			end
			ST_SORT:   if (!need_swap && i_q + 7'd1 >= held_q) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_ready) cmd_q <= cmd;
		if (state_q == ST_SEARCH && cmd_q.mode == MODE_UPSERT && cmd_q.ok) begin
			logic [IW-1:0] w;
			logic          wr;
			w  = kx;
			wr = 1'b0;
			if (k_q < held_q && hit) wr = 1'b1;
			else if (k_q >= held_q && held_q < Cap) begin
				w = held_q[IW-1:0]; wr = 1'b1;
			end else if (k_q >= held_q &&
			             $signed(cmd_q.rssi) > $signed(rs_q[IW'(CAPACITY-1)])) begin
				w = IW'(CAPACITY-1); wr = 1'b1;
			end
			if (wr) begin
				id_q[w]   <= cmd_q.identity;
				idl_q[w]  <= cmd_q.identity_length;
				rs_q[w]   <= cmd_q.rssi;
				lab_q[w]  <= cmd_q.label;
				labl_q[w] <= cmd_q.label_length;
			end
		end
		if (state_q == ST_SORT && need_swap) begin
			id_q[jm1] <= id_q[jx];     id_q[jx] <= id_q[jm1];
			idl_q[jm1] <= idl_q[jx];   idl_q[jx] <= idl_q[jm1];
			rs_q[jm1] <= rs_q[jx];     rs_q[jx] <= rs_q[jm1];
			lab_q[jm1] <= lab_q[jx];   lab_q[jx] <= lab_q[jm1];
			labl_q[jm1] <= labl_q[jx]; labl_q[jx] <= labl_q[jm1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			held_q     <= '0;
			rev_q      <= '0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			busy_out_q <= 1'b0;
			chg_q      <= 1'b0;
			changed               <= 1'b0;
			entry_valid           <= 1'b0;
			entry_identity        <= '0;
			entry_identity_length <= '0;
			entry_rssi            <= '0;
			entry_label           <= '0;
			entry_label_length    <= '0;
			entry_count           <= '0;
			revision              <= '0;
		end else begin
			state_q <= state_d;
			if (busy_out_q && out_ready) busy_out_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					k_q   <= '0;
					chg_q <= 1'b0;
				end
				ST_SEARCH: begin
					i_q <= 7'd1;
					j_q <= 7'd1;
					if (cmd_q.mode == MODE_UPSERT && cmd_q.ok) begin
						if (k_q < held_q && !hit) k_q <= k_q + 7'd1;
						if (state_d == ST_SORT) begin
							chg_q <= 1'b1;
							rev_q <= rev_q + 32'd1;
							if (!(k_q < held_q) && held_q < Cap) held_q <= held_q + 7'd1;
						end
					end else if (cmd_q.mode == MODE_CLEAR) begin
						held_q <= '0;
						rev_q  <= rev_q + 32'd1;
					end
				end
				ST_SORT: begin
					// walk j down while swapping, then advance i
					if (need_swap) j_q <= j_q - 7'd1;
					else begin
						i_q <= i_q + 7'd1;
						j_q <= i_q + 7'd1;
					end
				end
				ST_DONE: begin
					busy_out_q  <= 1'b1;
					changed     <= chg_q;
					entry_count <= held_q;
					revision    <= rev_q;
					if (cmd_q.mode == MODE_READ && in_range) begin
						entry_valid           <= 1'b1;
						entry_identity        <= id_q[ix];
						entry_identity_length <= idl_q[ix];
						entry_rssi            <= rs_q[ix];
						entry_label           <= lab_q[ix];
						entry_label_length    <= labl_q[ix];
					end else begin
						entry_valid           <= 1'b0;
						entry_identity        <= '0;
						entry_identity_length <= '0;
						entry_rssi            <= '0;
						entry_label           <= '0;
						entry_label_length    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) held_q <= Cap)
		else $error("entry count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(revision))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT |-> j_q <= i_q)
		else $error("sort index out of order");

endmodule

// File: src/strongest_k_device_table_unit.sv
// Strongest-k device table: a front queue feeding a sequential table engine.
// Path: the front queue registers each item; the back end then steps IDLE, SEARCH and DONE,
// with SORT between SEARCH and DONE for an accepted upsert, and loads the result registers in DONE.
// The back end takes one item at a time, and no new one until its result is taken; an upsert
// searches the held entries in order, then insertion-sorts them by RSSI, strongest first.
// Reset (arst_n low) empties the table and zeroes the revision at once.
// Depends on skdt_pkg, skdt_front, skdt_back.
module strongest_k_device_table_unit import skdt_pkg::*; #(
	parameter int CAPACITY    = 16,
	parameter int ID_BYTES    = 8,
	parameter int LABEL_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        is_ble,
	input  logic [63:0] identity,
	input  logic [3:0]  identity_length,
	input  logic signed [7:0] rssi,
	input  logic [63:0] label,
	input  logic [3:0]  label_length,
	input  logic [5:0]  entry_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        changed,
	output logic        entry_valid,
	output logic [63:0] entry_identity,
	output logic [3:0]  entry_identity_length,
	output logic signed [7:0] entry_rssi,
	output logic [63:0] entry_label,
	output logic [3:0]  entry_label_length,
	output logic [6:0]  entry_count,
	output logic [31:0] revision
);

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	skdt_front #(.ID_BYTES(ID_BYTES), .LABEL_BYTES(LABEL_BYTES)) u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .mode, .is_ble,
		.identity, .identity_length, .rssi, .label, .label_length, .entry_index,
		.cmd_valid, .cmd_ready, .cmd
	);

	skdt_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
		.changed, .entry_valid, .entry_identity, .entry_identity_length,
		.entry_rssi, .entry_label, .entry_label_length, .entry_count, .revision
	);

endmodule
